// ----- hdl/cbs_pkg.sv -----
// Shared types and constants of the cubic Bezier segmenter.
package cbs_pkg;

  // Width of the subdivision level field
  localparam int LVL_W = 4;
  // Width of the polynomial coefficients, enough for 12 * 32768
  localparam int CO_W = 20;
  // Entries of the job queue between front and back
  localparam int JOB_DEPTH = 2;

  // One curve as it arrives
  typedef struct packed {
    logic signed [15:0] p1_x;
    logic signed [15:0] p1_y;
    logic signed [15:0] p2_x;
    logic signed [15:0] p2_y;
    logic signed [15:0] p3_x;
    logic signed [15:0] p3_y;
    logic signed [15:0] p4_x;
    logic signed [15:0] p4_y;
    logic [LVL_W-1:0]   subdiv_level;
    logic [15:0]        color;
  } curve_t;

  // One result transaction
  typedef struct packed {
    logic signed [15:0] seg_x0;
    logic signed [15:0] seg_y0;
    logic signed [15:0] seg_x1;
    logic signed [15:0] seg_y1;
    logic               seg_valid;
    logic               last;
    logic [15:0]        seg_color;
  } seg_t;

  // Classified curve: clamped level and polynomial coefficients
  typedef struct packed {
    logic signed [CO_W-1:0] ax;
    logic signed [CO_W-1:0] bx;
    logic signed [CO_W-1:0] cx;
    logic signed [CO_W-1:0] ay;
    logic signed [CO_W-1:0] by;
    logic signed [CO_W-1:0] cy;
    logic signed [15:0]     p1_x;
    logic signed [15:0]     p1_y;
    logic [LVL_W-1:0]       lvl;
    logic [15:0]            color;
  } job_t;

  // Queue handshake seen by the back end
  typedef struct packed {
    logic empty;
    job_t head;
  } job_q_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_STEP
  } bk_state_t;

endpackage

// ----- hdl/cbs_front.sv -----
// Front end: clamps the level and forms the cubic coefficients of a curve.
module cbs_front import cbs_pkg::*; #(
  parameter int MAX_LEVEL = 6
) (
  input  curve_t curve,
  output job_t   job
);

  logic signed [CO_W-1:0] x1, x2, x3, x4, y1, y2, y3, y4;

  // Sign-extend the control points
  assign x1 = CO_W'(curve.p1_x);
  assign x2 = CO_W'(curve.p2_x);
  assign x3 = CO_W'(curve.p3_x);
  assign x4 = CO_W'(curve.p4_x);
  assign y1 = CO_W'(curve.p1_y);
  assign y2 = CO_W'(curve.p2_y);
  assign y3 = CO_W'(curve.p3_y);
  assign y4 = CO_W'(curve.p4_y);

  always_comb begin
    // Form a = -p1+3p2-3p3+p4, b = 3p1-6p2+3p3, c = -3p1+3p2
    job.ax = x4 - x1 + (x2 - x3) * CO_W'(3);
    job.bx = (x1 + x3) * CO_W'(3) - x2 * CO_W'(6);
    job.cx = (x2 - x1) * CO_W'(3);
    job.ay = y4 - y1 + (y2 - y3) * CO_W'(3);
    job.by = (y1 + y3) * CO_W'(3) - y2 * CO_W'(6);
    job.cy = (y2 - y1) * CO_W'(3);
    job.p1_x = curve.p1_x;
    job.p1_y = curve.p1_y;
    job.color = curve.color;
    // Clamp the level to 1..MAX_LEVEL
    if (curve.subdiv_level == '0) begin
      job.lvl = LVL_W'(1);
    end else if (curve.subdiv_level > LVL_W'(MAX_LEVEL)) begin
      job.lvl = LVL_W'(MAX_LEVEL);
    end else begin
      job.lvl = curve.subdiv_level;
    end
  end

endmodule

// ----- hdl/cbs_fifo.sv -----
// Short job queue between the front end and the back end.
module cbs_fifo import cbs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  job_t   wr_job,
  output logic   full,
  input  logic   rd,
  output job_q_t q
);

  localparam int AW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int NW = $clog2(JOB_DEPTH + 1);

  job_t          slots [JOB_DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [NW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == NW'(JOB_DEPTH));
  assign q.empty = (count == '0);
  assign q.head  = slots[rptr];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !q.empty;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(JOB_DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(JOB_DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + NW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - NW'(1);
      end
    end
  end

  // Hold the queued jobs
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_job;
    end
  end

endmodule

// ----- hdl/cbs_back.sv -----
// Back end: forward-difference walker with a one-entry result register.
module cbs_back import cbs_pkg::*; #(
  parameter int MAX_LEVEL = 6
) (
  input  logic   clk,
  input  logic   rst,
  input  job_q_t q,
  output logic   q_rd,
  output logic   empty,
  input  logic   pop,
  output seg_t   seg
);

  localparam int FRAC = 3 * MAX_LEVEL;
  localparam int W    = FRAC + 17;
  localparam int SW   = $clog2(FRAC + 1);
  localparam int CW   = MAX_LEVEL;

  typedef struct packed {
    logic [W-1:0] d1;
    logic [W-1:0] d2;
    logic [W-1:0] d3;
  } diff_t;

  bk_state_t state, state_next;

  job_t            job;
  logic [W-1:0]    xp, xd1, xd2, xd3;
  logic [W-1:0]    yp, yd1, yd2, yd3;
  logic [15:0]     px, py;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   last_idx;
  logic            out_valid;

  logic [SW-1:0]   sh0, sh1, sh2;
  diff_t           dx_init, dy_init;
  logic [W-1:0]    xn, yn;
  logic [15:0]     cx, cy;
  logic            moved;
  logic            at_last;
  logic            step_go;
  logic            load_out;

  // Integer part of a fixed-point position, truncated toward zero
  function automatic logic [15:0] trunc_pos(input logic [W-1:0] v);
    logic signed [W-1:0] ip;
    logic                adj;
    ip  = $signed(v) >>> FRAC;
    adj = v[W-1] && (|v[FRAC-1:0]);
    return ip[15:0] + {15'b0, adj};
  endfunction

  // Initial differences of one axis for shifts s, s+L and s+2L
  function automatic diff_t diff_setup(input logic signed [CO_W-1:0] a,
                                       input logic signed [CO_W-1:0] b,
                                       input logic signed [CO_W-1:0] c,
                                       input logic [SW-1:0] s0,
                                       input logic [SW-1:0] s1,
                                       input logic [SW-1:0] s2);
    logic [W-1:0] ea, eb, ec, a0, b1;
    diff_t        r;
    ea   = W'(a);
    eb   = W'(b);
    ec   = W'(c);
    a0   = ea << s0;
    b1   = eb << s1;
    r.d3 = (a0 << 2) + (a0 << 1);
    r.d2 = r.d3 + (b1 << 1);
    r.d1 = a0 + b1 + (ec << s2);
    return r;
  endfunction

  // Derive the difference shifts from the clamped level
  assign sh0 = SW'(FRAC) - SW'(3) * SW'(job.lvl);
  assign sh1 = sh0 + SW'(job.lvl);
  assign sh2 = sh1 + SW'(job.lvl);
  assign dx_init = diff_setup(job.ax, job.bx, job.cx, sh0, sh1, sh2);
  assign dy_init = diff_setup(job.ay, job.by, job.cy, sh0, sh1, sh2);

  // Evaluate one step and decide whether it yields a transaction
  assign xn       = xp + xd1;
  assign yn       = yp + yd1;
  assign cx       = trunc_pos(xn);
  assign cy       = trunc_pos(yn);
  assign moved    = (cx != px) || (cy != py);
  assign at_last  = (cnt == last_idx);
  assign step_go  = (state == ST_STEP) && (!out_valid || pop);
  assign load_out = step_go && (moved || at_last);
  assign empty    = !out_valid;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and queue read
  always_comb begin
    state_next = state;
    q_rd       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q.empty) begin
          q_rd       = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = ST_STEP;
      end
      ST_STEP: begin
        if (step_go && at_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Load the job, set up the differences and advance the walk
  always_ff @(posedge clk) begin
    if (q_rd) begin
      job <= q.head;
    end
    if (state == ST_SETUP) begin
      xp       <= W'(job.p1_x) << FRAC;
      yp       <= W'(job.p1_y) << FRAC;
      xd1      <= dx_init.d1;
      xd2      <= dx_init.d2;
      xd3      <= dx_init.d3;
      yd1      <= dy_init.d1;
      yd2      <= dy_init.d2;
      yd3      <= dy_init.d3;
      px       <= job.p1_x;
      py       <= job.p1_y;
      cnt      <= '0;
      last_idx <= ~({CW{1'b1}} << job.lvl);
    end else if (step_go) begin
      xp  <= xn;
      yp  <= yn;
      xd1 <= xd1 + xd2;
      xd2 <= xd2 + xd3;
      yd1 <= yd1 + yd2;
      yd2 <= yd2 + yd3;
      px  <= cx;
      py  <= cy;
      cnt <= cnt + CW'(1);
    end
  end

  // Hold the result until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the result transaction
  always_ff @(posedge clk) begin
    if (load_out) begin
      seg.seg_x0    <= moved ? px : '0;
      seg.seg_y0    <= moved ? py : '0;
      seg.seg_x1    <= moved ? cx : '0;
      seg.seg_y1    <= moved ? cy : '0;
      seg.seg_valid <= moved;
      seg.last      <= at_last;
      seg.seg_color <= job.color;
    end
  end

  a_setup_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_SETUP |=> state == ST_STEP)
    else $error("setup did not move on to stepping");

  a_rd_idle: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> state == ST_IDLE && !q.empty)
    else $error("job taken outside idle");

  a_final: assert property (@(posedge clk) disable iff (rst)
    step_go && at_last |=> state == ST_IDLE && out_valid && seg.last)
    else $error("final step did not leave a last transaction");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_STEP |-> cnt <= last_idx)
    else $error("step counter ran past the final step");

endmodule

// ----- hdl/cubic_bezier_segmenter.sv -----
// Cubic Bezier segmenter: walks each curve by forward differencing.
// A new curve passes the job queue, the job register and the setup state before its first step.
// The difference walker makes one step per cycle,
// slowed only while the result register waits on pop.
// A two-entry job queue lets new curves be accepted while one is walked.
// Reset (rst, synchronous) empties the queue and idles the walker.
module cubic_bezier_segmenter import cbs_pkg::*; #(
  parameter int MAX_LEVEL = 6
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   full,
  input  curve_t curve,
  output logic   empty,
  input  logic   pop,
  output seg_t   seg
);

  job_t   job;
  job_q_t q;
  logic   q_rd;

  // Classify the incoming curve
  cbs_front #(
    .MAX_LEVEL(MAX_LEVEL)
  ) u_front (
    .curve(curve),
    .job  (job)
  );

  // Queue classified curves
  cbs_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wr_job(job),
    .full  (full),
    .rd    (q_rd),
    .q     (q)
  );

  // Walk the curve and emit segments
  cbs_back #(
    .MAX_LEVEL(MAX_LEVEL)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .q    (q),
    .q_rd (q_rd),
    .empty(empty),
    .pop  (pop),
    .seg  (seg)
  );

endmodule
